FILE: src/m3inv_pkg.sv
// Package for the 3x3 matrix inverse block: widths, element and result types.
// No dependencies.
package m3inv_pkg;

  localparam int ElemW = 32;
  localparam int CofW  = 66;   // exact cofactor, Q32.32 with growth
  localparam int DetW  = 100;  // exact determinant, Q48.48 with growth
  localparam int NumW  = 98;   // |cofactor| << 32
  localparam int QW    = 34;   // quotient bits kept before saturation
  localparam int ThrW  = 31;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct packed {
    logic [ElemW-1:0] r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
  } mat_pl_t;

  typedef struct packed {
    mat_pl_t m;
    logic    singular;
  } res_pl_t;

endpackage

FILE: src/m3inv_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type set by parameter.
interface m3inv_if #(parameter type PAYLOAD_T = logic) (input logic clk);
  logic     valid;
  logic     ready;
  PAYLOAD_T data;
  modport source (input clk, output valid, output data, input ready);
  modport sink (input clk, input valid, input data, output ready);
endinterface

FILE: src/m3inv_lane.sv
// One division lane: restoring divider for round(num / den), one bit per stage.
// Depends on m3inv_pkg.
module m3inv_lane (
  input  logic                            clk,
  input  logic                            adv,
  input  logic [m3inv_pkg::NumW-1:0]      num,
  input  logic [m3inv_pkg::DetW-1:0]      den,
  input  logic                            neg,
  output logic [m3inv_pkg::ElemW-1:0]     q_out
);
  import m3inv_pkg::*;
  // Quotient fits QW bits before saturation check; leading bits tracked as overflow.
  localparam int Steps = NumW;
  logic [DetW:0]     rem_r [Steps+1];
  logic [NumW-1:0]   n_r   [Steps+1];
  logic [QW-1:0]     q_r   [Steps+1];
  logic              ov_r  [Steps+1];
  logic [DetW-1:0]   d_r   [Steps+1];
  logic              neg_r [Steps+1];
  logic [QW-1:0]     qf;
  logic              of;

  always_comb begin
    rem_r[0] = '0; n_r[0] = num; q_r[0] = '0; ov_r[0] = 1'b0;
    d_r[0] = den; neg_r[0] = neg;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic [DetW:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_r[s][DetW-1:0], n_r[s][NumW-1]};
      ge = sh >= {1'b0, d_r[s]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= ge ? sh - {1'b0, d_r[s]} : sh;
        n_r[s+1]   <= n_r[s] << 1;
        q_r[s+1]   <= {q_r[s][QW-2:0], ge};
        ov_r[s+1]  <= ov_r[s] | q_r[s][QW-1];
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  always_comb begin
    // Round to nearest, ties away from zero.
    {of, qf} = {ov_r[Steps], q_r[Steps]}
             + {{QW{1'b0}}, ({rem_r[Steps][DetW-1:0], 1'b0} >= {1'b0, d_r[Steps]})};
    of = of | ov_r[Steps];
    if (!neg_r[Steps]) begin
      q_out = (of || qf > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qf[ElemW-1:0];
    end else begin
      q_out = (of || qf > QW'(32'h8000_0000)) ? 32'h8000_0000 : ElemW'(-qf);
    end
  end
endmodule

FILE: src/m3inv_front.sv
// Cofactor, determinant and threshold stages (registered after each multiply).
// Depends on m3inv_pkg.
module m3inv_front (
  input  logic                         clk,
  input  logic                         adv,
  input  m3inv_pkg::mat_pl_t           mat_in,
  input  logic [m3inv_pkg::ThrW-1:0]   thr,
  output logic [m3inv_pkg::CofW-1:0]   cof [9],
  output logic [m3inv_pkg::DetW-1:0]   det,
  output logic                         sing,
  output m3inv_pkg::mat_pl_t           mat_out
);
  import m3inv_pkg::*;
  logic signed [ElemW-1:0] e [9];
  logic signed [ElemW-1:0] ec [3];
  logic signed [63:0] p_r [18];
  logic signed [CofW-1:0] c_r [9];
  logic signed [CofW-1:0] c2_r [9];
  mat_pl_t m1_r, m2_r, m3_r, m4_r;
  logic signed [65:0] tl_r [3];
  logic signed [64:0] th_r [3];
  logic signed [DetW-1:0] t_r [3];
  logic [ThrW-1:0] thr2_r;
  logic signed [CofW-1:0] c3_r [9];
  // Product pairs: cof = e[a]*e[b] - e[c]*e[d].
  localparam int IA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int IB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int IC [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int ID [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  assign e = '{mat_in.r0c0, mat_in.r0c1, mat_in.r0c2, mat_in.r1c0, mat_in.r1c1,
               mat_in.r1c2, mat_in.r2c0, mat_in.r2c1, mat_in.r2c2};
  assign ec = '{m2_r.r0c0, m2_r.r1c0, m2_r.r2c0};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        p_r[2*i]   <= e[IA[i]] * e[IB[i]];
        p_r[2*i+1] <= e[IC[i]] * e[ID[i]];
      end
      m1_r <= mat_in;
      for (int i = 0; i < 9; i++) begin
        c_r[i] <= CofW'(p_r[2*i]) - CofW'(p_r[2*i+1]);
      end
      m2_r <= m1_r;
      // Expansion along column 0. Each 32x66 term is split at bit 33 of the
      // cofactor into two narrower products, recombined in the next stage.
      for (int k = 0; k < 3; k++) begin
        tl_r[k] <= ec[k] * $signed({1'b0, c_r[k][32:0]});
        th_r[k] <= ec[k] * $signed(c_r[k][CofW-1:33]);
      end
      c2_r <= c_r;
      m3_r <= m2_r;
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= (DetW'(th_r[k]) <<< 33) + DetW'(tl_r[k]);
      end
      c3_r <= c2_r;
      m4_r <= m3_r;
      thr2_r <= thr;
    end
  end

  logic signed [DetW-1:0] dsum;
  logic [DetW-1:0] dabs;
  always_comb begin
    dsum = t_r[0] + t_r[1] + t_r[2];
    dabs = dsum[DetW-1] ? DetW'(-dsum) : DetW'(dsum);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det     <= dsum;
      sing    <= (dsum == '0) || (dabs < {{(DetW-ThrW-32){1'b0}}, thr2_r, 32'd0});
      mat_out <= m4_r;
      for (int i = 0; i < 9; i++) cof[i] <= c3_r[i];
    end
  end
endmodule

FILE: src/matrix3x3_inverse.sv
// 3x3 matrix inverse, adjugate over determinant, Q16.16 in and out.
// 5 front stages plus 98 divider stages; one item per cycle when not stalled.
// All nine elements divide in nine parallel lanes fed from one determinant.
// A stall freezes the whole pipe; the last divider stage holds the result item.
// Synchronous active-low reset clears valid bits and sets threshold thr_r to 1.
module matrix3x3_inverse (
  input  logic                          clk,
  input  logic                          rst_n,
  m3inv_if.sink                         in_ch,
  m3inv_if.source                       out_ch,
  input  logic                          cfg_we,
  input  logic [m3inv_pkg::ThrW-1:0]    cfg_wdata
);
  import m3inv_pkg::*;
  localparam int Lat = 5 + NumW;
  logic [ThrW-1:0] thr_r;
  logic [Lat-1:0] v_r;
  logic adv;
  logic [CofW-1:0] cof [9];
  logic [DetW-1:0] det, dabs;
  logic sing;
  mat_pl_t mat_f;
  logic [ElemW-1:0] q [9];
  logic [NumW-1:0] sing_d;
  mat_pl_t mat_d [NumW];
  res_pl_t res;

  assign adv = out_ch.ready || !v_r[Lat-1];
  assign in_ch.ready = adv;
  assign out_ch.valid = v_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrW'(1);
      v_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (adv) v_r <= {v_r[Lat-2:0], in_ch.valid};
    end
  end

  m3inv_front u_front (.clk, .adv, .mat_in(in_ch.data), .thr(thr_r), .cof, .det,
                       .sing, .mat_out(mat_f));

  assign dabs = det[DetW-1] ? DetW'(-det) : det;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    logic [CofW-1:0] ca;
    assign ca = cof[i][CofW-1] ? CofW'(-cof[i]) : cof[i];
    m3inv_lane u_lane (.clk, .adv, .num({ca, 32'd0}), .den(dabs),
                       .neg(cof[i][CofW-1] ^ det[DetW-1]), .q_out(q[i]));
  end

  // Bypass line keeps the input matrix and flag aligned with the lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_d <= {sing_d[NumW-2:0], sing};
      mat_d[0] <= mat_f;
      for (int i = 1; i < NumW; i++) mat_d[i] <= mat_d[i-1];
    end
  end

  always_comb begin
    res.singular = sing_d[NumW-1];
    if (res.singular) res.m = mat_d[NumW-1];
    else res.m = '{q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8]};
  end
  assign out_ch.data = res;
endmodule

FILE: src/m3inv_checker.sv
// Port-level checks for matrix3x3_inverse; bound to the top level.
// Depends on m3inv_pkg and m3inv_if.
module m3inv_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input m3inv_pkg::res_pl_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready while empty");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("stall not seen");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, out_valid})) else $error("valid unknown");
endmodule

bind matrix3x3_inverse m3inv_props u_chk (.clk, .rst_n, .in_valid(in_ch.valid),
  .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data));

FILE: tb/sv/m3inv_checker.sv
`timescale 1ns / 1ps
// Checker for the 3x3 matrix inverse: watches the input, result and register ports,
// predicts each result item and compares it. Depends on m3inv_pkg.
module m3inv_checker
  import m3inv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  mat_pl_t         in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  res_pl_t         out_data,
  input  logic            cfg_we,
  input  logic [ThrW-1:0] cfg_wdata,
  output int              errors,
  output int              pending
);

  typedef logic signed [127:0] wide_t;

  res_pl_t          inverse_q[$];
  logic [ThrW-1:0]  threshold;

  function automatic logic [31:0] elem_at(mat_pl_t m, int idx);
    logic [9*ElemW-1:0] flat;
    flat = m;
    return flat[9*ElemW-1-ElemW*idx -: ElemW];
  endfunction

  function automatic wide_t widen(logic [31:0] v);
    elem_t s;
    wide_t w;
    s = v;
    w = s;
    return w;
  endfunction

  // Rounds |cof| * 2^32 / |det| to nearest with ties away from zero, then saturates.
  function automatic logic [31:0] divide_round(wide_t cof, wide_t det);
    logic [127:0] num, den, q, rem;
    logic         neg;
    neg = (cof < 0) != (det < 0);
    num = (cof < 0) ? -cof : cof;
    den = (det < 0) ? -det : det;
    num = num << 32;
    q   = num / den;
    rem = num - q * den;
    if ((rem << 1) >= den) q = q + 1;
    if (!neg) return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 128'h8000_0000) return 32'h8000_0000;
    return -q[31:0];
  endfunction

  function automatic res_pl_t predict_inverse(mat_pl_t m, logic [ThrW-1:0] thr);
    wide_t              e [9];
    wide_t              adj [9];
    wide_t              det, mag, lim;
    logic [9*ElemW-1:0] flat;
    res_pl_t            r;
    for (int i = 0; i < 9; i++) e[i] = widen(elem_at(m, i));
    adj[0] = e[4] * e[8] - e[7] * e[5];
    adj[1] = e[7] * e[2] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[4] * e[2];
    adj[3] = e[6] * e[5] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[6] * e[2];
    adj[5] = e[3] * e[2] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[6] * e[4];
    adj[7] = e[6] * e[1] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[3] * e[1];
    det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
    mag = (det < 0) ? -det : det;
    lim = {65'd0, thr, 32'd0};
    if (det == 0 || mag < lim) begin
      r.m = m;
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++)
      flat[9*ElemW-1-ElemW*i -: ElemW] = divide_round(adj[i], det);
    r.m = flat;
    r.singular = 1'b0;
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_pl_t want;
    if (!rst_n) begin
      threshold <= ThrW'(1);
      inverse_q.delete();
    end else begin
      if (in_valid && in_ready) inverse_q.push_back(predict_inverse(in_data, threshold));
      if (out_valid && out_ready) begin
        if (inverse_q.size() == 0) begin
          $error("result item with no expected item waiting");
          errors++;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (elem_at(out_data.m, i) !== elem_at(want.m, i)) begin
              $error("out_r%0dc%0d: expected %h, actual %h", i / 3, i % 3,
                     elem_at(want.m, i), elem_at(out_data.m, i));
              errors++;
            end
          if (out_data.singular !== want.singular) begin
            $error("singular: expected %b, actual %b", want.singular, out_data.singular);
            errors++;
          end
        end
      end
      if (cfg_we) threshold <= cfg_wdata;
    end
    pending = inverse_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the 3x3 matrix inverse testbench: clock, reset, stimulus and verdict.
// Depends on m3inv_pkg, m3inv_if, matrix3x3_inverse and m3inv_checker.
module testbench;
  import m3inv_pkg::*;

  localparam int Latency = 110;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [ThrW-1:0] cfg_wdata;
  int              errors;
  int              pending;
  bit              idling_on;
  bit              long_hold;

  m3inv_if #(.PAYLOAD_T(mat_pl_t)) in_if (clk);
  m3inv_if #(.PAYLOAD_T(res_pl_t)) out_if (clk);

  matrix3x3_inverse dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  m3inv_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off that backs up the pipe.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_matrix(mat_pl_t m);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= m;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic mat_pl_t make_matrix(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                          logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
                                          logic [31:0] a6, logic [31:0] a7, logic [31:0] a8);
    return {a0, a1, a2, a3, a4, a5, a6, a7, a8};
  endfunction

  function automatic logic [31:0] small_int();
    logic [31:0] v;
    v = ($urandom_range(0, 8) - 4) << 16;
    if ($urandom_range(0, 2) == 0) v = v + $urandom_range(0, 16'hFFFF);
    return v;
  endfunction

  function automatic logic [31:0] corner_elem();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic mat_pl_t random_matrix();
    logic [31:0] v [9];
    int          kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      case (kind)
        0, 1, 2, 3: v[i] = $urandom;
        4, 5, 6:    v[i] = small_int();
        7:          v[i] = $urandom_range(0, 511) - 256;
        8:          v[i] = small_int();
        default:    v[i] = corner_elem();
      endcase
    // Third row as the sum of the first two makes the matrix exactly singular.
    if (kind == 8)
      for (int c = 0; c < 3; c++) v[6 + c] = v[c] + v[3 + c];
    return make_matrix(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_matrix(random_matrix());
  endtask

  localparam logic [31:0] One = 32'h0001_0000;
  localparam logic [31:0] MinusOne = 32'hFFFF_0000;

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    idling_on    = 1'b1;
    long_hold    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases under the reset threshold.
    send_matrix(make_matrix(One, 0, 0, 0, One, 0, 0, 0, One));
    send_matrix(make_matrix(MinusOne, 0, 0, 0, One, 0, 0, 0, One));
    send_matrix('0);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix(make_matrix(32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, 32'h5555_5555));
    send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(32'h0000_0100, 0, 0, 0, 32'h0000_0100, 0, 0, 0, MinusOne));
    send_matrix(make_matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF));
    send_matrix(make_matrix(0, One, 0, One, 0, 0, 0, 0, MinusOne));
    send_matrix(make_matrix(32'h0002_0000, 0, 0, 0, 32'h0003_0000, 0, 0, 0, 32'h0007_0000));
    send_matrix(make_matrix(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 32'h0000_8000));

    // Zero threshold: only an exactly zero determinant is singular.
    write_threshold('0);
    send_matrix('0);
    send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(make_matrix(MinusOne, 0, 0, 0, 1, 0, 0, 0, 1));
    run_random(250);

    // Threshold of one unit, with the receiver backing up the pipe.
    write_threshold(31'h0001_0000);
    send_matrix(make_matrix(One, 0, 0, 0, One, 0, 0, 0, One));
    send_matrix(make_matrix(MinusOne, 0, 0, 0, One, 0, 0, 0, One));
    long_hold = 1'b1;
    run_random(300);

    // Largest threshold: nearly everything is singular.
    write_threshold(31'h7FFF_FFFF);
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix(make_matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
    run_random(250);

    write_threshold(ThrW'($urandom));
    run_random(250);

    // Back to the smallest nonzero threshold, then a final stretch with no idling.
    write_threshold(31'd1);
    run_random(150);
    idling_on = 1'b0;
    run_random(200);
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
